// File: rtl/hist_eq_pkg.sv
// Shared types and constants of the histogram equalizer.
// No dependencies; imported by every other file of the block except hist_eq_ram.
package hist_eq_pkg;

    localparam int LEVELS     = 256;
    localparam int LEVEL_BITS = 8;
    localparam int CFG_BITS   = 13;

    // Configuration register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [8:0] {
        ST_CLEAR    = 9'b000000001,
        ST_COUNT    = 9'b000000010,
        ST_COUNT_WR = 9'b000000100,
        ST_SUM_RD   = 9'b000001000,
        ST_SUM_ACC  = 9'b000010000,
        ST_DIV_RD   = 9'b000100000,
        ST_DIV_LD   = 9'b001000000,
        ST_DIV_IT   = 9'b010000000,
        ST_MAP      = 9'b100000000
    } state_t;

    typedef struct packed {
        logic idx_inc;       // advance level sweep index
        logic hist_rd_pix;   // read histogram at incoming red level
        logic hist_wr_pix;   // write back incremented count
        logic hist_rd_idx;   // read histogram at sweep index
        logic hist_wr_zero;  // zero histogram at sweep index
        logic sum_clr;       // clear running sum and min search
        logic sum_acc;       // accumulate one level in the first sweep
        logic div_load;      // load dividend/divisor for one level
        logic div_step;      // one quotient bit
        logic map_wr;        // write map entry at sweep index
        logic map_accept;    // mapping-pass pixel accepted
        logic pix_step;      // count one pixel of the current pass
    } cmd_t;

    typedef struct packed {
        logic idx_last;
        logic div_last;
        logic pass_end;      // this pixel closes the pass
        logic map_room;      // map pipeline can take a pixel
    } status_t;

endpackage

// File: rtl/hist_eq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hist_eq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/hist_eq_ctrl.sv
// Sequencer of the histogram equalizer: passes, clearing and map build.
// Depends on hist_eq_pkg.
module hist_eq_ctrl
    import hist_eq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  status_t st,
    output logic    in_ready,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.hist_wr_zero = 1'b1;
                cmd.idx_inc      = 1'b1;
                if (st.idx_last)
                begin
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.hist_rd_pix = 1'b1;
                    state_next      = ST_COUNT_WR;
                end
            end
            ST_COUNT_WR:
            begin
                cmd.hist_wr_pix = 1'b1;
                cmd.pix_step    = 1'b1;
                if (st.pass_end)
                begin
                    cmd.sum_clr = 1'b1;
                    state_next  = ST_SUM_RD;
                end
                else
                begin
                    state_next = ST_COUNT;
                end
            end
            ST_SUM_RD:
            begin
                cmd.hist_rd_idx = 1'b1;
                state_next      = ST_SUM_ACC;
            end
            ST_SUM_ACC:
            begin
                cmd.sum_acc = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = st.idx_last ? ST_DIV_RD : ST_SUM_RD;
            end
            ST_DIV_RD:
            begin
                cmd.hist_rd_idx = 1'b1;
                state_next      = ST_DIV_LD;
            end
            ST_DIV_LD:
            begin
                cmd.div_load     = 1'b1;
                cmd.hist_wr_zero = 1'b1;
                state_next       = ST_DIV_IT;
            end
            ST_DIV_IT:
            begin
                cmd.div_step = 1'b1;
                if (st.div_last)
                begin
                    cmd.map_wr  = 1'b1;
                    cmd.idx_inc = 1'b1;
                    state_next  = st.idx_last ? ST_MAP : ST_DIV_RD;
                end
            end
            ST_MAP:
            begin
                in_ready = st.map_room;
                if (in_valid && st.map_room)
                begin
                    cmd.map_accept = 1'b1;
                    cmd.pix_step   = 1'b1;
                    if (st.pass_end)
                    begin
                        state_next = ST_COUNT;
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    a_ready_state: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == ST_COUNT || state_reg == ST_MAP))
        else $error("input ready outside a pixel pass");

    a_map_after_build: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAP && $past(state_reg) != ST_MAP)
            |-> $past(state_reg) == ST_DIV_IT)
        else $error("mapping pass entered without map build");

    a_sum_after_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM_RD && $past(state_reg) == ST_COUNT_WR)
            |-> $past(st.pass_end))
        else $error("map build started before end of counting pass");

endmodule

// File: rtl/hist_eq_datapath.sv
// Datapath: histogram store, pixel counter, cumulative sum, divider, map RAMs.
// Depends on hist_eq_pkg and hist_eq_ram.
module hist_eq_datapath
    import hist_eq_pkg::*;
#(
    parameter int MAX_SIDE   = 4096,
    parameter int COUNT_BITS = 25
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [CFG_BITS-1:0] image_width,
    input  logic [CFG_BITS-1:0] image_height,
    input  cmd_t                cmd,
    output status_t             st,
    input  logic [31:0]         in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         out_data,
    output logic                out_last
);

    localparam int CB  = COUNT_BITS;
    localparam int SW  = $clog2(MAX_SIDE + 1);
    localparam int NW  = 2 * SW;
    localparam int CW  = (NW > CB) ? NW : CB;
    localparam int DW  = CB + 10;
    localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};

    // ---- frame size ----
    logic [13:0]   w_ext, h_ext;
    logic [SW-1:0] w_c, h_c;
    logic [NW-1:0] n_pix;

    assign w_ext = {1'b0, image_width};
    assign h_ext = {1'b0, image_height};

    always_comb
    begin
        if (w_ext == 14'd0)
            w_c = SW'(1);
        else if (w_ext > 14'(MAX_SIDE))
            w_c = SW'(MAX_SIDE);
        else
            w_c = SW'(w_ext);
        if (h_ext == 14'd0)
            h_c = SW'(1);
        else if (h_ext > 14'(MAX_SIDE))
            h_c = SW'(MAX_SIDE);
        else
            h_c = SW'(h_ext);
    end

    assign n_pix = NW'(w_c) * NW'(h_c);

    // ---- pixel counter ----
    logic [CB-1:0] pix_cnt_reg, pix_cnt_inc;

    assign pix_cnt_inc = (pix_cnt_reg == CNT_MAX) ? CNT_MAX : pix_cnt_reg + 1'b1;
    assign st.pass_end = (CW'(pix_cnt_inc) >= CW'(n_pix)) || (pix_cnt_inc == CNT_MAX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pix_cnt_reg <= '0;
        else if (cmd.pix_step)
            pix_cnt_reg <= st.pass_end ? '0 : pix_cnt_inc;
    end

    // ---- sweep index ----
    logic [LEVEL_BITS-1:0] idx_reg;

    assign st.idx_last = (idx_reg == LEVEL_BITS'(LEVELS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else if (cmd.idx_inc)
            idx_reg <= idx_reg + 1'b1;
    end

    // ---- histogram store ----
    logic [LEVEL_BITS-1:0] red_reg;
    logic [LEVEL_BITS-1:0] h_raddr, h_waddr;
    logic [CB-1:0]         h_rdata, h_wdata;

    always_ff @(posedge clk)
    begin
        if (cmd.hist_rd_pix)
            red_reg <= in_data[7:0];
    end

    assign h_raddr = cmd.hist_rd_pix ? in_data[7:0] : idx_reg;
    assign h_waddr = cmd.hist_wr_pix ? red_reg : idx_reg;
    assign h_wdata = cmd.hist_wr_pix ?
                     ((h_rdata == CNT_MAX) ? CNT_MAX : h_rdata + 1'b1) : '0;

    hist_eq_ram #(.WIDTH(CB), .DEPTH(LEVELS)) u_hist (
        .clk   (clk),
        .we    (cmd.hist_wr_pix | cmd.hist_wr_zero),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .re    (cmd.hist_rd_pix | cmd.hist_rd_idx),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    // ---- cumulative sum and lowest occupied level ----
    logic [CB-1:0] run_reg, total_reg, minc_reg, cdf, den;
    logic          found_reg;

    assign cdf = CB'(run_reg + h_rdata);
    assign den = total_reg - minc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= '0;
            total_reg <= '0;
            minc_reg  <= '0;
            found_reg <= 1'b0;
        end
        else if (cmd.sum_clr)
        begin
            run_reg   <= '0;
            found_reg <= 1'b0;
            minc_reg  <= '0;
        end
        else if (cmd.sum_acc)
        begin
            if (!found_reg && h_rdata != '0)
            begin
                minc_reg  <= cdf;
                found_reg <= 1'b1;
            end
            if (st.idx_last)
            begin
                total_reg <= cdf;
                run_reg   <= '0;
            end
            else
            begin
                run_reg <= cdf;
            end
        end
        else if (cmd.div_load)
        begin
            run_reg <= cdf;
        end
    end

    // ---- restoring divider, one quotient bit per cycle ----
    // q = (num*510 + den) / (2*den), always below 256
    logic [DW-1:0]         rem_reg, ds_reg, num_w;
    logic [LEVEL_BITS-1:0] q_reg;
    logic [2:0]            dcnt_reg;
    logic                  zero_reg;
    logic                  ge;

    assign num_w       = DW'(cdf - minc_reg);
    assign ge          = (rem_reg >= ds_reg);
    assign st.div_last = (dcnt_reg == 3'd7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dcnt_reg <= '0;
        else if (cmd.div_load)
            dcnt_reg <= '0;
        else if (cmd.div_step)
            dcnt_reg <= dcnt_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            rem_reg  <= (num_w << 9) - (num_w << 1) + DW'(den);
            ds_reg   <= DW'(den) << 8;
            q_reg    <= '0;
            zero_reg <= !found_reg || den == '0 || cdf < minc_reg;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? rem_reg - ds_reg : rem_reg;
            ds_reg  <= ds_reg >> 1;
            q_reg   <= {q_reg[LEVEL_BITS-2:0], ge};
        end
    end

    // ---- level map, one copy per mapped channel ----
    logic [LEVEL_BITS-1:0] map_wdata, last_q;
    logic [LEVEL_BITS-1:0] map_r, map_g, map_b;

    // the final quotient bit is taken in the same cycle as the write
    assign last_q    = {q_reg[LEVEL_BITS-2:0], ge};
    assign map_wdata = zero_reg ? '0 : last_q;

    hist_eq_ram #(.WIDTH(LEVEL_BITS), .DEPTH(LEVELS)) u_map_r (
        .clk(clk), .we(cmd.map_wr), .waddr(idx_reg), .wdata(map_wdata),
        .re(cmd.map_accept), .raddr(in_data[7:0]), .rdata(map_r));
    hist_eq_ram #(.WIDTH(LEVEL_BITS), .DEPTH(LEVELS)) u_map_g (
        .clk(clk), .we(cmd.map_wr), .waddr(idx_reg), .wdata(map_wdata),
        .re(cmd.map_accept), .raddr(in_data[15:8]), .rdata(map_g));
    hist_eq_ram #(.WIDTH(LEVEL_BITS), .DEPTH(LEVELS)) u_map_b (
        .clk(clk), .we(cmd.map_wr), .waddr(idx_reg), .wdata(map_wdata),
        .re(cmd.map_accept), .raddr(in_data[23:16]), .rdata(map_b));

    // ---- mapping pipeline: lookup stage then output register ----
    logic       p1_valid_reg;
    logic [7:0] p1_alpha_reg;
    logic       p1_last_reg;
    logic       move;

    assign move        = p1_valid_reg && (!out_valid || out_ready);
    assign st.map_room = !p1_valid_reg || move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            out_valid    <= 1'b0;
        end
        else
        begin
            if (cmd.map_accept)
                p1_valid_reg <= 1'b1;
            else if (move)
                p1_valid_reg <= 1'b0;
            if (move)
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.map_accept)
        begin
            p1_alpha_reg <= in_data[31:24];
            p1_last_reg  <= st.pass_end;
        end
        if (move)
        begin
            out_data <= {p1_alpha_reg, map_b, map_g, map_r};
            out_last <= p1_last_reg;
        end
    end

endmodule

// File: rtl/histogram_equalizer.sv
// Top level of the histogram equalizer: ports, configuration registers.
// Depends on hist_eq_pkg, hist_eq_ctrl, hist_eq_datapath (and hist_eq_ram).
//
// Each frame is streamed in twice in raster order. In the counting pass the
// red level of every item is counted into a 256-entry histogram and nothing
// comes out; each counted item is read and written back (read-modify-write on
// the single histogram RAM port) before the next item is taken. After the
// last item of that pass the block builds the level map with s_tready low: one
// sweep for the cumulative counts and lowest occupied level, then per level a
// read, a load and then 8 steps of the bit-serial divider. The map is
// map = round_half_up((cdf - min_cdf) * 255 / (N - min_cdf)), 0 when all
// pixels share one level. The histogram is zeroed during that second sweep.
// In the mapping pass red, green and blue go through the map and alpha is
// passed; one item per cycle is taken while the output side keeps up, and
// m_tlast marks the last item of the frame. After reset the histogram is
// zeroed level by level before the first item is taken. Width and height are
// clamped to 1..MAX_SIDE and should be written only while the block is idle.
module histogram_equalizer
    import hist_eq_pkg::*;
#(
    parameter int MAX_SIDE   = 4096,
    parameter int COUNT_BITS = 25
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,   // pixel_red, pixel_green, pixel_blue, pixel_alpha
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,   // out_red, out_green, out_blue, out_alpha
    output logic                m_tlast    // frame_end
);

    logic [CFG_BITS-1:0] width_reg, height_reg;
    cmd_t                cmd;
    status_t             st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_BITS'(256);
            height_reg <= CFG_BITS'(256);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    hist_eq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .st       (st),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    hist_eq_datapath #(
        .MAX_SIDE   (MAX_SIDE),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_width  (width_reg),
        .image_height (height_reg),
        .cmd          (cmd),
        .st           (st),
        .in_data      (s_tdata),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_data     (m_tdata),
        .out_last     (m_tlast)
    );

endmodule

// File: tb/sv/histogram_equalizer_tb.sv
// Self-checking testbench for histogram_equalizer: directed table, then random frames.
// Depends on hist_eq_pkg and the RTL of the block; no files are read.
module histogram_equalizer_tb;
    import hist_eq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SIDE   = 4096;
    localparam int COUNT_BITS = 25;
    localparam int WDOG_LIMIT = 20000;
    localparam int ITEM_GOAL  = 1650;

    typedef logic [COUNT_BITS-1:0] count_t;

    // one mapped pixel, red in the low byte as on m_tdata
    typedef struct packed {
        logic       last;
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } mapped_px_t;

    // directed stimulus row: either a register write or a pixel
    typedef struct {
        bit                  is_cfg;
        logic                idx;
        logic [CFG_BITS-1:0] val;
        logic [31:0]         pix;
        bit                  typed;         // expected result given in the row
        mapped_px_t          res;
    } stim_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic                cfg_index = REG_WIDTH;
    logic [CFG_BITS-1:0] cfg_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [31:0]         s_tdata = '0;      // pixel_red, pixel_green, pixel_blue, pixel_alpha
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [31:0]         m_tdata;           // out_red, out_green, out_blue, out_alpha
    logic                m_tlast;           // frame_end

    histogram_equalizer #(.MAX_SIDE(MAX_SIDE), .COUNT_BITS(COUNT_BITS)) dut (.*);

    always #4 clk = ~clk;

    // ---------------------------------------------------------------
    // Predictor state: its own copy of registers, histogram and map
    // ---------------------------------------------------------------
    logic [CFG_BITS-1:0] width_reg = 13'd256;
    logic [CFG_BITS-1:0] height_reg = 13'd256;
    count_t              hist [LEVELS];
    logic [7:0]          lut [LEVELS];
    count_t              px_in_pass = '0;
    bit                  mapping_pass = 1'b0;

    mapped_px_t pending_px[$];
    bit         failed = 1'b0;
    int         items_sent = 0;
    bit         quiet_src = 1'b0;   // no sender gaps while set

    function automatic longint clamp_side(logic [CFG_BITS-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_SIDE) return MAX_SIDE;
        return v;
    endfunction

    function automatic count_t sat_inc(count_t v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // Cumulative counts, lowest occupied level and the rounded map; clears histogram.
    function automatic void build_lut();
        longint cdf [LEVELS];
        longint run, minc, den, num, q;
        bit     found;
        run = 0; minc = 0; found = 0;
        for (int g = 0; g < LEVELS; g++) begin
            run += hist[g];
            cdf[g] = run;
            if (!found && hist[g] != 0) begin
                minc = run;
                found = 1;
            end
        end
        den = run - minc;
        for (int g = 0; g < LEVELS; g++) begin
            q = 0;
            if (found && den != 0 && cdf[g] >= minc) begin
                num = cdf[g] - minc;
                q = (num * 510 + den) / (2 * den);
                if (q > 255) q = 255;
            end
            lut[g] = q[7:0];
            hist[g] = '0;
        end
    endfunction

    // Advance the model by one accepted pixel; returns 1 when a result is due.
    function automatic bit equalize_px(logic [31:0] pix, output mapped_px_t res);
        longint n;
        bit     done;
        n = clamp_side(width_reg) * clamp_side(height_reg);
        res = '0;
        px_in_pass = sat_inc(px_in_pass);
        done = (px_in_pass >= n) || (&px_in_pass);
        if (!mapping_pass) begin
            hist[pix[7:0]] = sat_inc(hist[pix[7:0]]);
            if (done) begin
                build_lut();
                px_in_pass = '0;
                mapping_pass = 1'b1;
            end
            return 1'b0;
        end
        res.red   = lut[pix[7:0]];
        res.green = lut[pix[15:8]];
        res.blue  = lut[pix[23:16]];
        res.alpha = pix[31:24];
        res.last  = done;
        if (done) begin
            px_in_pass = '0;
            mapping_pass = 1'b0;
        end
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Driving
    // ---------------------------------------------------------------
    // Register writes only while idle: nothing pending, then a short settle.
    task automatic write_reg(logic idx, logic [CFG_BITS-1:0] val);
        s_tvalid <= 1'b0;
        while (pending_px.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_WIDTH) width_reg = val;
        else height_reg = val;
    endtask

    // Present one item; valid stays high afterwards unless a gap follows.
    task automatic send_px(logic [31:0] pix, bit typed, mapped_px_t typed_res);
        mapped_px_t res;
        bit         due;
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do @(posedge clk); while (!s_tready);
        due = equalize_px(pix, res);
        if (due) pending_px.push_back(typed ? typed_res : res);
        items_sent++;
        if (!quiet_src && $urandom_range(99) < 16) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
    endtask

    // Random pixel whose red level follows one of a few frame styles.
    function automatic logic [31:0] frame_px(int style, logic [7:0] base);
        logic [31:0] p;
        p = $urandom;
        case (style)
            1: p[7:0] = base;                                   // one level: zero spread
            2: p[7:0] = base + 8'($urandom_range(3));           // narrow band
            3: p[7:0] = $urandom_range(1) ? base : ~base;       // two levels
            default: ;
        endcase
        return p;
    endfunction

    // ---------------------------------------------------------------
    // Receiver: random back-pressure, with a long run of none
    // ---------------------------------------------------------------
    int cyc = 0;
    always @(posedge clk) begin
        cyc <= cyc + 1;
        if (cyc > 6000 && cyc < 10000) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(99) >= 16);
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge clk) begin
        mapped_px_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_px.size() == 0) begin
                $display("%0t: unexpected result data=%h last=%b", $realtime, m_tdata, m_tlast);
                failed = 1'b1;
            end else begin
                want = pending_px.pop_front();
                if (m_tdata[7:0] !== want.red)
                    $display("%0t: out_red expected %h actual %h",
                             $realtime, want.red, m_tdata[7:0]);
                if (m_tdata[15:8] !== want.green)
                    $display("%0t: out_green expected %h actual %h",
                             $realtime, want.green, m_tdata[15:8]);
                if (m_tdata[23:16] !== want.blue)
                    $display("%0t: out_blue expected %h actual %h",
                             $realtime, want.blue, m_tdata[23:16]);
                if (m_tdata[31:24] !== want.alpha)
                    $display("%0t: out_alpha expected %h actual %h",
                             $realtime, want.alpha, m_tdata[31:24]);
                if (m_tlast !== want.last)
                    $display("%0t: frame_end expected %b actual %b",
                             $realtime, want.last, m_tlast);
                if (m_tdata !== {want.alpha, want.blue, want.green, want.red} ||
                    m_tlast !== want.last)
                    failed = 1'b1;
            end
        end
    end

    // Watchdog: cycles in which neither side moves an item.
    int stuck = 0;
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stuck <= 0;
        else stuck <= stuck + 1;
        if (stuck >= WDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    stim_row_t dir_rows[$];

    task automatic add_cfg(logic idx, logic [CFG_BITS-1:0] val);
        stim_row_t r;
        r = '{default: '0};
        r.is_cfg = 1; r.idx = idx; r.val = val;
        dir_rows.push_back(r);
    endtask

    task automatic add_px(logic [31:0] pix, bit typed = 0, mapped_px_t res = '0);
        stim_row_t r;
        r = '{default: '0};
        r.pix = pix; r.typed = typed; r.res = res;
        dir_rows.push_back(r);
    endtask

    initial begin
        int          w, h, n, style;
        logic [7:0]  base;
        int          frame_no;

        for (int g = 0; g < LEVELS; g++) begin
            hist[g] = '0;
            lut[g] = '0;
        end

        // 1x1 frame: a single level gives a zero spread, map is all zero
        add_cfg(REG_WIDTH, 13'd1);
        add_cfg(REG_HEIGHT, 13'd1);
        add_px(32'h0000_0000);
        add_px(32'hFF80_FF00, 1, '{last: 1'b1, alpha: 8'hFF, default: 8'h00});
        // zero sizes count as one
        add_cfg(REG_WIDTH, 13'd0);
        add_cfg(REG_HEIGHT, 13'd0);
        add_px(32'h00FF_FFFF);
        add_px(32'h00FF_FFFF, 1, '{last: 1'b1, alpha: 8'h00, default: 8'h00});
        // two extreme levels: 0 maps to 0, 255 to 255
        add_cfg(REG_WIDTH, 13'd2);
        add_cfg(REG_HEIGHT, 13'd1);
        add_px(32'h1234_5600);
        add_px(32'h6543_21FF);
        add_px(32'h5AFF_00FF, 1, '{last: 1'b0, alpha: 8'h5A, red: 8'hFF, green: 8'h00, blue: 8'hFF});
        add_px(32'hA500_FF00, 1, '{last: 1'b1, alpha: 8'hA5, red: 8'h00, green: 8'hFF, blue: 8'h00});
        // 3x2 with uneven counts, checked by the predictor
        add_cfg(REG_WIDTH, 13'd3);
        add_cfg(REG_HEIGHT, 13'd2);
        add_px(32'h0000_0000); add_px(32'h0000_0001); add_px(32'h0000_0001);
        add_px(32'h0000_0002); add_px(32'h0000_0080); add_px(32'h0000_00FF);
        add_px(32'hFF02_0100); add_px(32'h0080_FF01); add_px(32'h7F00_0202);
        add_px(32'h80FF_8080); add_px(32'h0101_03FF); add_px(32'hC3FE_7F40);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) write_reg(dir_rows[i].idx, dir_rows[i].val);
            else send_px(dir_rows[i].pix, dir_rows[i].typed, dir_rows[i].res);
        end

        // Random frames, mostly small: a counting pass in one style, then random pixels.
        frame_no = 0;
        while (items_sent < ITEM_GOAL) begin
            w = $urandom_range(8, 1);
            h = $urandom_range(8, 1);
            if (frame_no == 5) begin
                w = 0;              // zero width counts as one
                write_reg(REG_WIDTH, 13'd0);
                write_reg(REG_HEIGHT, h[CFG_BITS-1:0]);
            end else begin
                write_reg(REG_WIDTH, w[CFG_BITS-1:0]);
                write_reg(REG_HEIGHT, h[CFG_BITS-1:0]);
            end
            n = int'(clamp_side(width_reg) * clamp_side(height_reg));
            style = $urandom_range(3);
            base = 8'($urandom);
            quiet_src = (items_sent > 600 && items_sent < 900);
            for (int k = 0; k < n; k++) send_px(frame_px(style, base), 0, '0);
            for (int k = 0; k < n; k++) begin
                // hold off mid-frame until the output side has drained
                if (frame_no == 3 && k == n / 2) begin
                    s_tvalid <= 1'b0;
                    while (pending_px.size() != 0) @(posedge clk);
                end
                send_px($urandom, 0, '0);
            end
            frame_no++;
        end
        s_tvalid <= 1'b0;

        while (pending_px.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (!failed && pending_px.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
